// ===== src/tmc_pkg.sv =====
package tmc_pkg;

   // Filter and screen geometry.
   localparam int WINDOW_SIZE   = 5;
   localparam int SCREEN_WIDTH  = 480;
   localparam int SCREEN_HEIGHT = 320;

   // Field widths.
   localparam int RAW_W = 12;
   localparam int OUT_W = 9;

   // Largest raw reading, used by the mirror step.
   localparam logic [RAW_W-1:0] RAW_MAX = '1;

   // Ring position and rank widths follow the window size.
   localparam int SLOT_W      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int RANK_W      = $clog2(WINDOW_SIZE) + 1;
   localparam int MEDIAN_RANK = WINDOW_SIZE / 2;

   // Scaling widths: the product of a raw difference and a screen size.
   localparam int SCREEN_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
   localparam int SIZE_W     = $clog2(SCREEN_MAX + 1);
   localparam int PROD_W     = RAW_W + SIZE_W;
   localparam int STEP_W     = $clog2(PROD_W);

   localparam logic [SIZE_W-1:0] WIDTH_SIZE  = SIZE_W'(SCREEN_WIDTH);
   localparam logic [SIZE_W-1:0] HEIGHT_SIZE = SIZE_W'(SCREEN_HEIGHT);

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = RAW_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_SPAN_LOW  = 3'd0,
      CSR_X_SPAN_HIGH = 3'd1,
      CSR_Y_SPAN_LOW  = 3'd2,
      CSR_Y_SPAN_HIGH = 3'd3,
      CSR_SWAP_AXES   = 3'd4,
      CSR_MIRROR_X    = 3'd5,
      CSR_MIRROR_Y    = 3'd6
   } csr_index_type;

   // Request commands.
   localparam logic CMD_SAMPLE  = 1'b0;
   localparam logic CMD_RELEASE = 1'b1;

   // Window write control shared by both lanes.
   typedef struct packed {
      logic              write;
      logic              fill;
      logic [SLOT_W-1:0] slot;
   } lane_ctrl_type;

endpackage

// ===== src/tmc_req_if.sv =====
interface tmc_req_if import tmc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [RAW_W-1:0] raw_x;
   logic [RAW_W-1:0] raw_y;

   modport source (output valid, output cmd, output raw_x, output raw_y, input ready);
   modport sink (input valid, input cmd, input raw_x, input raw_y, output ready);
endinterface

// ===== src/tmc_rsp_if.sv =====
interface tmc_rsp_if import tmc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] col;
   logic [OUT_W-1:0] row;
   logic             pressed;

   modport source (output valid, output col, output row, output pressed,
                   input ready);
   modport sink (input valid, input col, input row, input pressed,
                 output ready);
endinterface

// ===== src/tmc_csr_if.sv =====
interface tmc_csr_if import tmc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/touch_median_calibrate.sv =====
// Touch filter and calibrator. Each sample transfer carries a raw X/Y
// pair that enters a five-entry ring window per axis; the first sample
// after reset or after a release fills the whole window. The two window
// medians are optionally swapped and mirrored, then scaled linearly
// between the programmed low and high raw values onto a 480 x 320 screen
// and clamped; a zero span maps that axis to 0. A release transfer unprimes
// the windows, so the next sample refills them, and repeats the last
// coordinates with pressed low. The scaling divider retires one quotient
// bit per cycle; a new request is taken only after the current item has
// been handed to the output register. The next request is taken while a
// finished result still waits on the response channel. Configuration is
// accepted at any time and should be written only while no item is in
// flight.
module touch_median_calibrate import tmc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   tmc_req_if.sink     req_ch,
   tmc_rsp_if.source   rsp_ch,
   tmc_csr_if.sink     csr_ch
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_MEDIAN = 5'b00010,
      ST_MERGE  = 5'b00100,
      ST_SCALE  = 5'b01000,
      ST_EMIT   = 5'b10000
   } top_state_type;

   top_state_type state_ff, state_in;

   logic [RAW_W-1:0]  x_low_ff, x_high_ff, y_low_ff, y_high_ff;
   logic              swap_ff, mirror_x_ff, mirror_y_ff;

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              primed_ff, primed_in;
   logic              pressed_ff, pressed_in;
   logic [OUT_W-1:0]  held_x_ff, held_y_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]  rsp_x_ff, rsp_y_ff;
   logic              rsp_pressed_ff;

   logic              req_take;
   logic              csr_take;
   logic              emit;
   lane_ctrl_type     lane_ctrl;
   logic [RAW_W-1:0]  median_x, median_y;
   logic [RAW_W-1:0]  merged_x, merged_y;
   logic              scale_start;
   logic              x_done, y_done;
   logic [OUT_W-1:0]  x_result, y_result;

   assign req_take = req_ch.valid && req_ch.ready;
   assign csr_take = csr_ch.valid && csr_ch.ready;
   assign emit     = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);

   // Configuration registers.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_low_ff    <= '0;
         x_high_ff   <= RAW_MAX;
         y_low_ff    <= '0;
         y_high_ff   <= RAW_MAX;
         swap_ff     <= 1'b0;
         mirror_x_ff <= 1'b0;
         mirror_y_ff <= 1'b0;
      end else if (csr_take) begin
         unique case (csr_ch.index)
            CSR_X_SPAN_LOW:  x_low_ff    <= csr_ch.data;
            CSR_X_SPAN_HIGH: x_high_ff   <= csr_ch.data;
            CSR_Y_SPAN_LOW:  y_low_ff    <= csr_ch.data;
            CSR_Y_SPAN_HIGH: y_high_ff   <= csr_ch.data;
            CSR_SWAP_AXES:   swap_ff     <= csr_ch.data[0];
            CSR_MIRROR_X:    mirror_x_ff <= csr_ch.data[0];
            CSR_MIRROR_Y:    mirror_y_ff <= csr_ch.data[0];
            default: begin
            end
         endcase
      end
   end

   // Window bookkeeping shared by both lanes.
   assign lane_ctrl.write = req_take && (req_ch.cmd == CMD_SAMPLE);
   assign lane_ctrl.fill  = !primed_ff;
   assign lane_ctrl.slot  = slot_ff;

   always_comb begin
      slot_in    = slot_ff;
      primed_in  = primed_ff;
      pressed_in = pressed_ff;
      if (req_take) begin
         pressed_in = (req_ch.cmd == CMD_SAMPLE);
         if (req_ch.cmd == CMD_RELEASE) begin
            slot_in   = '0;
            primed_in = 1'b0;
         end else begin
            primed_in = 1'b1;
            slot_in   = (slot_ff == SLOT_W'(WINDOW_SIZE - 1)) ? '0 : slot_ff + SLOT_W'(1);
         end
      end
   end

   // Per-axis lanes: window and median.
   tmc_lane u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .raw    (req_ch.raw_x),
      .median (median_x)
   );

   tmc_lane u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (lane_ctrl),
      .raw    (req_ch.raw_y),
      .median (median_y)
   );

   // Merge the lane results: optional axis swap, then mirroring.
   always_comb begin
      merged_x = swap_ff ? median_y : median_x;
      merged_y = swap_ff ? median_x : median_y;
      if (mirror_x_ff) begin
         merged_x = RAW_MAX - merged_x;
      end
      if (mirror_y_ff) begin
         merged_y = RAW_MAX - merged_y;
      end
   end

   assign scale_start = (state_ff == ST_MERGE);

   tmc_scale u_scale_x (
      .clock     (clock),
      .reset     (reset),
      .start     (scale_start),
      .value     (merged_x),
      .span_low  (x_low_ff),
      .span_high (x_high_ff),
      .size      (WIDTH_SIZE),
      .done      (x_done),
      .result    (x_result)
   );

   tmc_scale u_scale_y (
      .clock     (clock),
      .reset     (reset),
      .start     (scale_start),
      .value     (merged_y),
      .span_low  (y_low_ff),
      .span_high (y_high_ff),
      .size      (HEIGHT_SIZE),
      .done      (y_done),
      .result    (y_result)
   );

   // Item sequencer.
   assign req_ch.ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_ch.cmd == CMD_RELEASE) ? ST_EMIT : ST_MEDIAN;
            end
         end
         ST_MEDIAN: begin
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (x_done && y_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output register frees when its transfer completes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         primed_ff    <= 1'b0;
         pressed_ff   <= 1'b0;
         held_x_ff    <= '0;
         held_y_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         primed_ff    <= primed_in;
         pressed_ff   <= pressed_in;
         rsp_valid_ff <= rsp_valid_in;
         if ((state_ff == ST_SCALE) && x_done && y_done) begin
            held_x_ff <= x_result;
            held_y_ff <= y_result;
         end
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_x_ff       <= held_x_ff;
         rsp_y_ff       <= held_y_ff;
         rsp_pressed_ff <= pressed_ff;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.col     = rsp_x_ff;
   assign rsp_ch.row     = rsp_y_ff;
   assign rsp_ch.pressed = rsp_pressed_ff;

endmodule

// ===== src/tmc_lane.sv =====
module tmc_lane import tmc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  lane_ctrl_type    ctrl,
   input  logic [RAW_W-1:0] raw,
   output logic [RAW_W-1:0] median
);

   logic [RAW_W-1:0]  window_ff [WINDOW_SIZE];
   logic [RANK_W-1:0] rank      [WINDOW_SIZE];
   logic [RAW_W-1:0]  median_in;
   logic [RAW_W-1:0]  median_ff;

   // Ring write; an unprimed window takes the sample in every entry.
   always_ff @(posedge clock) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         if (ctrl.write && (ctrl.fill || ctrl.slot == SLOT_W'(i))) begin
            window_ff[i] <= raw;
         end
      end
   end

   // Stable rank of each entry: smaller values, and equal values at lower
   // positions, come first. The entry whose rank is the middle index is the
   // median of the sorted window.
   always_comb begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WINDOW_SIZE; j++) begin
            if (j != i) begin
               if ((window_ff[j] < window_ff[i]) ||
                   ((window_ff[j] == window_ff[i]) && (j < i))) begin
                  rank[i] = rank[i] + RANK_W'(1);
               end
            end
         end
      end
   end

   // Exactly one entry holds the middle rank, so an OR of the gated values selects it.
   always_comb begin
      median_in = '0;
      for (int i = 0; i < WINDOW_SIZE; i++) begin
         if (rank[i] == RANK_W'(MEDIAN_RANK)) begin
            median_in = median_in | window_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         median_ff <= '0;
      end else begin
         median_ff <= median_in;
      end
   end

   assign median = median_ff;

endmodule

// ===== src/tmc_scale.sv =====
module tmc_scale import tmc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RAW_W-1:0]  value,
   input  logic [RAW_W-1:0]  span_low,
   input  logic [RAW_W-1:0]  span_high,
   input  logic [SIZE_W-1:0] size,
   output logic              done,
   output logic [OUT_W-1:0]  result
);

   typedef enum logic [3:0] {
      SC_IDLE = 4'b0001,
      SC_MUL  = 4'b0010,
      SC_DIV  = 4'b0100,
      SC_DONE = 4'b1000
   } scale_state_type;

   scale_state_type   state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              done_ff, done_in;

   logic [RAW_W:0]    diff;
   logic [RAW_W:0]    span;
   logic [RAW_W-1:0]  mag_ff;
   logic [RAW_W-1:0]  den_ff;
   logic              neg_ff;
   logic              zero_ff;
   logic [PROD_W-1:0] quot_ff;
   logic [RAW_W-1:0]  rem_ff;
   logic [RAW_W:0]    trial;
   logic              fits;
   logic [PROD_W-1:0] size_wide;
   logic [PROD_W-1:0] clamped;
   logic [OUT_W-1:0]  result_ff;

   // Signed difference and span, one bit wider than a raw value.
   assign diff = {1'b0, value} - {1'b0, span_low};
   assign span = {1'b0, span_high} - {1'b0, span_low};

   // One restoring division step on the magnitudes.
   assign trial = {rem_ff, quot_ff[PROD_W-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   // Negative quotients and a zero span go to zero; large ones to the last pixel.
   assign size_wide = {{(PROD_W-SIZE_W){1'b0}}, size};
   always_comb begin
      priority if (neg_ff || zero_ff) begin
         clamped = '0;
      end else if (quot_ff >= size_wide) begin
         clamped = size_wide - PROD_W'(1);
      end else begin
         clamped = quot_ff;
      end
   end

   // Sequencer: load, multiply, one quotient bit per cycle, clamp.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               state_in = SC_MUL;
            end
         end
         SC_MUL: begin
            step_in  = '0;
            state_in = SC_DIV;
         end
         SC_DIV: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(PROD_W - 1)) begin
               state_in = SC_DONE;
            end
         end
         SC_DONE: begin
            done_in  = 1'b1;
            state_in = SC_IDLE;
         end
         default: begin
            state_in = SC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         SC_IDLE: begin
            if (start) begin
               mag_ff  <= diff[RAW_W] ? RAW_W'(-diff) : diff[RAW_W-1:0];
               den_ff  <= span[RAW_W] ? RAW_W'(-span) : span[RAW_W-1:0];
               neg_ff  <= diff[RAW_W] ^ span[RAW_W];
               zero_ff <= (span == '0);
            end
         end
         SC_MUL: begin
            quot_ff <= PROD_W'(mag_ff) * PROD_W'(size);
            rem_ff  <= '0;
         end
         SC_DIV: begin
            rem_ff  <= fits ? RAW_W'(trial - {1'b0, den_ff}) : trial[RAW_W-1:0];
            quot_ff <= {quot_ff[PROD_W-2:0], fits};
         end
         SC_DONE: begin
            result_ff <= clamped[OUT_W-1:0];
         end
         default: begin
         end
      endcase
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== src/tmc_checker.sv =====
module tmc_checker import tmc_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OUT_W-1:0] rsp_col,
   input logic [OUT_W-1:0] rsp_row,
   input logic             rsp_pressed
);

   // A stalled response stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before its transfer");

   // A stalled response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_col) && $stable(rsp_row) && $stable(rsp_pressed))
      else $error("response payload changed while stalled");

   // Column lies on the screen.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_col < OUT_W'(SCREEN_WIDTH)))
      else $error("screen column out of range");

   // Row lies on the screen.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_row < OUT_W'(SCREEN_HEIGHT)))
      else $error("screen row out of range");

endmodule

bind touch_median_calibrate tmc_checker u_tmc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_col     (rsp_ch.col),
   .rsp_row     (rsp_ch.row),
   .rsp_pressed (rsp_ch.pressed)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import tmc_pkg::*;

   // Tracks the block's filter and calibration state and holds the
   // coordinates that each accepted request should produce.
   class tracker_type;
      typedef struct {
         logic [OUT_W-1:0] x;
         logic [OUT_W-1:0] y;
         logic             pressed;
      } coord_type;

      coord_type pending[$];

      // Calibration registers at their reset values.
      logic [RAW_W-1:0] x_low = '0;
      logic [RAW_W-1:0] x_high = RAW_MAX;
      logic [RAW_W-1:0] y_low = '0;
      logic [RAW_W-1:0] y_high = RAW_MAX;
      logic swap_xy = 1'b0;
      logic flip_x = 1'b0;
      logic flip_y = 1'b0;

      // Filter state.
      logic [RAW_W-1:0] win_x [WINDOW_SIZE] = '{default: '0};
      logic [RAW_W-1:0] win_y [WINDOW_SIZE] = '{default: '0};
      int unsigned      slot = 0;
      bit               primed = 1'b0;
      logic [OUT_W-1:0] held_x = '0;
      logic [OUT_W-1:0] held_y = '0;

      int failures = 0;
      int checked = 0;
      int touches = 0;
      int lifts = 0;

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_X_SPAN_LOW:  x_low = data;
            CSR_X_SPAN_HIGH: x_high = data;
            CSR_Y_SPAN_LOW:  y_low = data;
            CSR_Y_SPAN_HIGH: y_high = data;
            CSR_SWAP_AXES:   swap_xy = data[0];
            CSR_MIRROR_X:    flip_x = data[0];
            CSR_MIRROR_Y:    flip_y = data[0];
            default: ;
         endcase
      endfunction

      // The median is the entry whose rank range covers the middle rank.
      function logic [RAW_W-1:0] window_median(logic [RAW_W-1:0] w [WINDOW_SIZE]);
         int below;
         int not_above;
         for (int i = 0; i < WINDOW_SIZE; i++) begin
            below = 0;
            not_above = 0;
            for (int j = 0; j < WINDOW_SIZE; j++) begin
               if (w[j] < w[i]) below++;
               if (w[j] <= w[i]) not_above++;
            end
            if (below <= MEDIAN_RANK && MEDIAN_RANK < not_above) return w[i];
         end
         return '0;
      endfunction

      // Linear map with truncating signed division, then clamp to the screen.
      function logic [OUT_W-1:0] scale_axis(int v, int lo, int hi, int size);
         int span;
         int r;
         span = hi - lo;
         if (span == 0) r = 0;
         else r = ((v - lo) * size) / span;
         if (r < 0) r = 0;
         if (r >= size) r = size - 1;
         return OUT_W'(r);
      endfunction

      function void note_request(logic cmd, logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry);
         coord_type c;
         logic [RAW_W-1:0] fx;
         logic [RAW_W-1:0] fy;
         logic [RAW_W-1:0] t;
         if (cmd == CMD_RELEASE) begin
            win_x = '{default: '0};
            win_y = '{default: '0};
            slot = 0;
            primed = 1'b0;
            c = '{held_x, held_y, 1'b0};
            lifts++;
         end else begin
            win_x[slot] = rx;
            win_y[slot] = ry;
            slot = (slot + 1) % WINDOW_SIZE;
            // The first point of a touch fills the whole window.
            if (!primed) begin
               win_x = '{default: rx};
               win_y = '{default: ry};
               primed = 1'b1;
            end
            fx = window_median(win_x);
            fy = window_median(win_y);
            if (swap_xy) begin
               t = fx;
               fx = fy;
               fy = t;
            end
            if (flip_x) fx = RAW_MAX - fx;
            if (flip_y) fy = RAW_MAX - fy;
            held_x = scale_axis(int'(fx), int'(x_low), int'(x_high), SCREEN_WIDTH);
            held_y = scale_axis(int'(fy), int'(y_low), int'(y_high), SCREEN_HEIGHT);
            c = '{held_x, held_y, 1'b1};
            touches++;
         end
         pending.push_back(c);
      endfunction

      function void note_failure(string what);
         failures++;
         if (failures <= 10) $display("MISMATCH at %0t ns: %s", $time, what);
      endfunction

      function void check_coords(logic [OUT_W-1:0] sx, logic [OUT_W-1:0] sy, logic pressed);
         coord_type want;
         if (pending.size() == 0) begin
            note_failure($sformatf("response x=%0d y=%0d pressed=%0b with nothing pending",
                                   sx, sy, pressed));
         end else begin
            want = pending.pop_front();
            checked++;
            if (sx !== want.x || sy !== want.y || pressed !== want.pressed) begin
               note_failure($sformatf("expected x=%0d y=%0d pressed=%0b, got x=%0d y=%0d pressed=%0b",
                                      want.x, want.y, want.pressed, sx, sy, pressed));
            end
         end
      endfunction
   endclass

   typedef struct {
      logic             cmd;
      logic [RAW_W-1:0] x;
      logic [RAW_W-1:0] y;
   } touch_req_type;

   typedef struct {
      logic [RAW_W-1:0] x_low;
      logic [RAW_W-1:0] x_high;
      logic [RAW_W-1:0] y_low;
      logic [RAW_W-1:0] y_high;
      logic             swap_xy;
      logic             flip_x;
      logic             flip_y;
   } calib_type;

   typedef enum {RX_ALWAYS, RX_PATTERN, RX_RANDOM} rx_mode_type;

   localparam int SETTLE_CYCLES = 40;
   localparam int PHASE_ITEMS   = 153;

   logic clock = 1'b0;
   logic reset;

   tmc_req_if req_ch ();
   tmc_rsp_if rsp_ch ();
   tmc_csr_if csr_ch ();

   touch_median_calibrate dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   tracker_type   tracker = new;
   touch_req_type req_plan[$];
   rx_mode_type   rx_mode = RX_ALWAYS;
   logic [15:0]   rx_pattern = 16'hFFFF;
   int unsigned   rx_pos = 0;
   int            settings_used = 1;

   always #2 clock = ~clock;

   // Watch all three channels; every transfer updates the tracker.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) begin
            tracker.set_register(csr_index_type'(csr_ch.index), csr_ch.data);
         end
         if (req_ch.valid && req_ch.ready) begin
            tracker.note_request(req_ch.cmd, req_ch.raw_x, req_ch.raw_y);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_coords(rsp_ch.col, rsp_ch.row, rsp_ch.pressed);
         end
      end
   end

   // Response back-pressure follows the mode of the current phase.
   always @(negedge clock) begin
      case (rx_mode)
         RX_ALWAYS:  rsp_ch.ready <= 1'b1;
         RX_PATTERN: rsp_ch.ready <= rx_pattern[rx_pos % 16];
         default:    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
      rx_pos <= rx_pos + 1;
   end

   function automatic void plan(logic cmd, logic [RAW_W-1:0] x, logic [RAW_W-1:0] y);
      touch_req_type r;
      r = '{cmd, x, y};
      req_plan.push_back(r);
   endfunction

   function automatic logic [RAW_W-1:0] any_raw();
      return RAW_W'($urandom_range(0, int'(RAW_MAX)));
   endfunction

   // Raw value biased toward the two ends of the range.
   function automatic logic [RAW_W-1:0] edge_biased_raw();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return RAW_MAX;
         default: return any_raw();
      endcase
   endfunction

   function automatic logic [RAW_W-1:0] jitter(int c, int amp);
      int v;
      v = c - amp + int'($urandom_range(0, 2 * amp));
      if (v < 0) v = 0;
      if (v > int'(RAW_MAX)) v = int'(RAW_MAX);
      return RAW_W'(v);
   endfunction

   function automatic calib_type random_calib();
      calib_type c;
      c.x_low  = edge_biased_raw();
      c.x_high = edge_biased_raw();
      c.y_low  = edge_biased_raw();
      c.y_high = edge_biased_raw();
      // A realistic calibration window, a degenerate span or random edge-biased spans.
      case ($urandom_range(0, 5))
         0: c.x_high = c.x_low;
         1: c.y_high = c.y_low;
         2, 3: begin
            c.x_low  = RAW_W'($urandom_range(100, 900));
            c.x_high = RAW_W'($urandom_range(3200, 4000));
            c.y_low  = RAW_W'($urandom_range(100, 900));
            c.y_high = RAW_W'($urandom_range(3200, 4000));
         end
         default: ;
      endcase
      c.swap_xy = 1'($urandom_range(0, 1));
      c.flip_x  = 1'($urandom_range(0, 1));
      c.flip_y  = 1'($urandom_range(0, 1));
      return c;
   endfunction

   // Queue touch sessions: mostly press-drag-lift sequences, plus noise
   // and sessions that never lift.
   task automatic plan_random(int n);
      int made;
      int pick;
      int len;
      int cx;
      int cy;
      int amp;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(0, 99);
         len = $urandom_range(1, 12);
         cx = int'(edge_biased_raw());
         cy = int'(edge_biased_raw());
         case ($urandom_range(0, 2))
            0:       amp = 0;
            1:       amp = 15;
            default: amp = 200;
         endcase
         if (pick < 75) begin
            for (int k = 0; k < len; k++) begin
               // An occasional wild reading that the median should reject.
               if ($urandom_range(0, 9) == 0) plan(CMD_SAMPLE, any_raw(), any_raw());
               else plan(CMD_SAMPLE, jitter(cx, amp), jitter(cy, amp));
            end
            plan(CMD_RELEASE, any_raw(), any_raw());
            made += len + 1;
         end else if (pick < 90) begin
            len = $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
               plan($urandom_range(0, 1) ? CMD_RELEASE : CMD_SAMPLE, any_raw(), any_raw());
            end
            made += len;
         end else begin
            for (int k = 0; k < len; k++) plan(CMD_SAMPLE, jitter(cx, amp), jitter(cy, amp));
            made += len;
         end
      end
   endtask

   // Send the planned requests in bursts with random gaps between them.
   task automatic drive_requests(int gap_max, int burst_max);
      touch_req_type r;
      int burst_left;
      int gap;
      burst_left = $urandom_range(1, burst_max);
      while (req_plan.size() > 0) begin
         r = req_plan.pop_front();
         req_ch.valid <= 1'b1;
         req_ch.cmd   <= r.cmd;
         req_ch.raw_x <= r.x;
         req_ch.raw_y <= r.y;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         @(negedge clock);
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, burst_max);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
      req_ch.valid <= 1'b0;
   endtask

   // Write all calibration registers back to back.
   task automatic write_config(calib_type c);
      csr_index_type idx;
      idx = idx.first();
      do begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= idx;
         case (idx)
            CSR_X_SPAN_LOW:  csr_ch.data <= c.x_low;
            CSR_X_SPAN_HIGH: csr_ch.data <= c.x_high;
            CSR_Y_SPAN_LOW:  csr_ch.data <= c.y_low;
            CSR_Y_SPAN_HIGH: csr_ch.data <= c.y_high;
            CSR_SWAP_AXES:   csr_ch.data <= CSR_DATA_W'(c.swap_xy);
            CSR_MIRROR_X:    csr_ch.data <= CSR_DATA_W'(c.flip_x);
            default:         csr_ch.data <= CSR_DATA_W'(c.flip_y);
         endcase
         @(posedge clock);
         while (!csr_ch.ready) @(posedge clock);
         @(negedge clock);
         idx = idx.next();
      end while (idx != idx.first());
      csr_ch.valid <= 1'b0;
   endtask

   // Wait for every expected response, then let the pipeline settle.
   task automatic wait_idle();
      while (tracker.pending.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(calib_type c, int gap_max, int burst_max, rx_mode_type mode);
      write_config(c);
      settings_used++;
      rx_mode = mode;
      rx_pattern = 16'($urandom()) | 16'h0101;
      plan_random(PHASE_ITEMS);
      drive_requests(gap_max, burst_max);
      wait_idle();
   endtask

   // Overall time limit for the run.
   initial begin
      #5000000;
      $display("touch_median_calibrate test failed");
      $finish;
   end

   initial begin
      calib_type c;
      int leftover;

      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.cmd   = CMD_SAMPLE;
      req_ch.raw_x = '0;
      req_ch.raw_y = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_X_SPAN_LOW;
      csr_ch.data  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed pass at reset calibration: a release before any touch,
      // window fill from the first point, the median walking to full
      // scale, extreme corners, and alternating bit patterns.
      plan(CMD_RELEASE, RAW_MAX, RAW_MAX);
      plan(CMD_SAMPLE, '0, '0);
      repeat (4) plan(CMD_SAMPLE, RAW_MAX, RAW_MAX);
      plan(CMD_SAMPLE, 12'hAAA, 12'h555);
      plan(CMD_RELEASE, '0, '0);
      plan(CMD_SAMPLE, RAW_MAX, '0);
      plan(CMD_RELEASE, 12'h555, 12'hAAA);
      plan(CMD_SAMPLE, '0, RAW_MAX);
      plan(CMD_SAMPLE, 12'h555, 12'hAAA);
      plan(CMD_SAMPLE, 12'hAAA, 12'h555);
      plan(CMD_RELEASE, '0, '0);
      plan(CMD_RELEASE, '0, '0);
      plan(CMD_SAMPLE, 12'd2048, 12'd2048);
      plan(CMD_SAMPLE, 12'd1, 12'd4094);
      plan(CMD_RELEASE, '0, '0);
      rx_mode = RX_ALWAYS;
      drive_requests(0, 1);
      wait_idle();

      // Full range with every flag set, no idling on either side.
      c = '{'0, RAW_MAX, '0, RAW_MAX, 1'b1, 1'b1, 1'b1};
      run_phase(c, 0, 1, RX_ALWAYS);
      // Inverted X span and a zero Y span.
      c = '{RAW_MAX, '0, 12'd2000, 12'd2000, 1'b0, 1'b1, 1'b0};
      run_phase(c, 6, 8, RX_PATTERN);
      // Narrow window so many points fall off the screen.
      c = '{12'd1000, 12'd3000, 12'd500, 12'd3500, 1'b1, 1'b0, 1'b1};
      run_phase(c, 35, 4, RX_RANDOM);
      // Zero spans at both ends of the raw range.
      c = '{'0, '0, RAW_MAX, RAW_MAX, 1'b0, 1'b0, 1'b0};
      run_phase(c, 3, 6, RX_PATTERN);
      // Both spans fully inverted.
      c = '{RAW_MAX, '0, RAW_MAX, '0, 1'b1, 1'b1, 1'b0};
      run_phase(c, 10, 3, RX_RANDOM);
      // Random calibrations with random pacing.
      repeat (5) begin
         run_phase(random_calib(), $urandom_range(0, 30), $urandom_range(1, 10),
                   rx_mode_type'($urandom_range(0, 2)));
      end

      leftover = tracker.pending.size();
      if (leftover != 0) begin
         tracker.failures += leftover;
         $display("%0d expected responses never arrived", leftover);
      end
      $display("Ran %0d touch points and %0d releases under %0d calibration settings.",
               tracker.touches, tracker.lifts, settings_used);
      $display("Compared %0d responses, %0d failures.", tracker.checked, tracker.failures);
      if (tracker.failures == 0) begin
         $display("touch_median_calibrate test passed");
      end else begin
         $display("touch_median_calibrate test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/tmc_pkg.sv
src/tmc_req_if.sv
src/tmc_rsp_if.sv
src/tmc_csr_if.sv
src/tmc_lane.sv
src/tmc_scale.sv
src/touch_median_calibrate.sv
src/tmc_checker.sv
tb/tb_top.sv
